>>> hw/rtl/timed_event_list_sequencer_top_macros.svh
// assertion helpers for the event list sequencer
`ifndef TIMED_EVENT_LIST_SEQUENCER_TOP_MACROS_SVH
`define TIMED_EVENT_LIST_SEQUENCER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TELS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tels assertion failed");
// next-cycle implication
`define TELS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tels assertion failed");
`else
`define TELS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TELS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/tels_pkg.sv
`default_nettype none

package tels_pkg;

    localparam int NUM_LISTS = 8;
    localparam int MAX_STEPS = 16;
    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int POS_W     = STEP_W + 1;
    localparam int ADDR_W    = LIST_W + STEP_W;
    localparam int CFG_W     = 4;
    localparam int MS_W      = 16;
    localparam int ELAPSED_W = 32;
    localparam int EVENT_W   = 8;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    localparam logic [1:0] KIND_FIRE   = 2'd0;
    localparam logic [1:0] KIND_WAIT   = 2'd1;
    localparam logic [1:0] KIND_REPEAT = 2'd2;
    localparam logic [1:0] KIND_SKIP   = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [MS_W-1:0]    interval;
        logic [MS_W-1:0]    repeats;
        logic [EVENT_W-1:0] event_id;
    } step_t;

    typedef enum logic {
        ALU_ADD_SAT,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [ELAPSED_W-1:0] a;
        logic [ELAPSED_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] result;
        logic                 ge;
    } alu_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/tels_step_mem.sv
`default_nettype none

module tels_step_mem
    import tels_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire step_t             wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output step_t                  rdata
);

    step_t mem [NUM_LISTS*MAX_STEPS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tels_alu.sv
`default_nettype none

module tels_alu
    import tels_pkg::*;
(
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [ELAPSED_W:0] sum;
    logic [ELAPSED_W:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb begin
        unique case (req.op)
            ALU_ADD_SAT: begin
                // saturate the elapsed time at all ones
                rsp.result = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];
                rsp.ge     = sum[ELAPSED_W];
            end
            ALU_SUB: begin
                rsp.result = diff[ELAPSED_W-1:0];
                rsp.ge     = ~diff[ELAPSED_W];
            end
            default: begin
                rsp.result = diff[ELAPSED_W-1:0];
                rsp.ge     = ~diff[ELAPSED_W];
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/timed_event_list_sequencer_top.sv
`default_nettype none
// channel   dir  tdata fields (low bit up)                         tuser     tlast
// s_*       in   list_index, step_index, step_kind, step_interval,  req_type  step_is_last
//                step_repeats, step_event, tick_ms, pad
// m_*       out  fired_list, event_id, any_running, pad             fired     last_result
// cfg_*     in   lists_in_use
//
// load, start, stop: accept, then the status state loads the status item into the output register
// tick: accept, then per list read (an idle list stops here), execute (skip stops here; fire goes to emit;
// wait and repeat go to compare, a due repeat on to repeat then emit), then status after the last list
// emit and status cycles stall while the output register holds an item not yet taken
// aresetn clears the list state and the register; the step memory is not cleared

module timed_event_list_sequencer_top
    import tels_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // list_index, step_index, step_kind, step_interval, step_repeats, step_event, tick_ms
    input  wire logic [71:0]      s_tdata,
    // req_type
    input  wire logic [1:0]       s_tuser,
    input  wire logic             s_tlast,

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // fired_list, event_id, any_running
    output logic [15:0]           m_tdata,
    // fired
    output logic                  m_tuser,
    output logic                  m_tlast,

    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    `include "timed_event_list_sequencer_top_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_REP  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_STAT = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [CFG_W-1:0]     cfg_reg;
    logic [LIST_W-1:0]    list_reg;
    logic [MS_W-1:0]      dt_reg;
    logic [EVENT_W-1:0]   ev_reg;
    logic                 any_reg;

    logic                 running_reg [NUM_LISTS];
    logic [POS_W-1:0]     len_reg     [NUM_LISTS];
    logic [POS_W-1:0]     pos_reg     [NUM_LISTS];
    logic [MS_W-1:0]      rep_reg     [NUM_LISTS];
    logic [ELAPSED_W-1:0] elapsed_reg [NUM_LISTS];

    logic                 m_valid_reg;
    logic [LIST_W-1:0]    m_list_reg;
    logic [EVENT_W-1:0]   m_event_reg;
    logic                 m_any_reg;
    logic                 m_fired_reg;
    logic                 m_last_reg;

    // input fields
    logic [1:0]        in_req;
    logic [LIST_W-1:0] in_list;
    logic [STEP_W-1:0] in_step;
    step_t             in_entry;
    logic [MS_W-1:0]   in_tick;

    assign in_req            = s_tuser;
    assign in_list           = s_tdata[2:0];
    assign in_step           = s_tdata[6:3];
    assign in_entry.kind     = s_tdata[8:7];
    assign in_entry.interval = s_tdata[24:9];
    assign in_entry.repeats  = s_tdata[40:25];
    assign in_entry.event_id = s_tdata[48:41];
    assign in_tick           = s_tdata[64:49];

    logic in_acc;
    logic tick_acc;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign tick_acc = in_acc && (in_req == REQ_TICK);

    logic out_free;
    logic stat_out;
    assign out_free = !m_valid_reg || m_tready;
    assign stat_out = (state_reg == S_STAT) && out_free;

    // step memory
    step_t             step_q;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    assign rd_addr = {list_reg, pos_reg[list_reg][STEP_W-1:0]};
    assign mem_we  = in_acc && (in_req == REQ_LOAD);

    tels_step_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr ({in_list, in_step}),
        .wdata (in_entry),
        .re    (state_reg == S_RD),
        .raddr (rd_addr),
        .rdata (step_q)
    );

    // shared add / compare unit
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    always_comb begin
        unique case (state_reg)
            S_EXEC: begin
                alu_req.op = ALU_ADD_SAT;
                alu_req.a  = elapsed_reg[list_reg];
                alu_req.b  = {{(ELAPSED_W-MS_W){1'b0}}, dt_reg};
            end
            S_REP: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ELAPSED_W-MS_W){1'b0}}, rep_reg[list_reg]};
                alu_req.b  = {{(ELAPSED_W-MS_W){1'b0}}, step_q.repeats};
            end
            default: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = elapsed_reg[list_reg];
                alu_req.b  = {{(ELAPSED_W-MS_W){1'b0}}, step_q.interval};
            end
        endcase
    end

    tels_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    logic last_list;
    logic cur_live;
    logic any_live;
    logic any_run;

    assign last_list = (list_reg == LIST_W'(NUM_LISTS - 1));
    assign cur_live  = pos_reg[list_reg] < len_reg[list_reg];

    // any list running, and any running list with steps still left
    always_comb begin
        any_live = 1'b0;
        any_run  = 1'b0;
        for (int i = 0; i < NUM_LISTS; i++) begin
            any_live = any_live | (running_reg[i] & (pos_reg[i] < len_reg[i]));
            any_run  = any_run | running_reg[i];
        end
    end

    logic [2:0] after_list;
    assign after_list = last_list ? S_STAT : S_RD;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = tick_acc ? S_RD : S_STAT;
                end
            end
            S_RD: begin
                if (running_reg[list_reg] && cur_live) begin
                    state_next = S_EXEC;
                end else begin
                    state_next = after_list;
                end
            end
            S_EXEC: begin
                unique case (step_q.kind)
                    KIND_FIRE:   state_next = S_EMIT;
                    KIND_WAIT:   state_next = S_CMP;
                    KIND_REPEAT: state_next = S_CMP;
                    KIND_SKIP:   state_next = after_list;
                    default:     state_next = after_list;
                endcase
            end
            S_CMP: begin
                if (alu_rsp.ge && (step_q.kind == KIND_REPEAT)) begin
                    state_next = S_REP;
                end else begin
                    state_next = after_list;
                end
            end
            S_REP:  state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    state_next = after_list;
                end
            end
            S_STAT: begin
                if (stat_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cfg_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            list_reg <= '0;
            dt_reg   <= in_tick;
            any_reg  <= any_live;
        end else if ((state_next == S_RD) && (state_reg != S_RD || !last_list)) begin
            list_reg <= list_reg + LIST_W'(1);
        end
        if (state_reg == S_EXEC || state_reg == S_CMP) begin
            ev_reg <= step_q.event_id;
        end
    end

    // per-list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                running_reg[i] <= 1'b0;
                len_reg[i]     <= '0;
                pos_reg[i]     <= '0;
                rep_reg[i]     <= '0;
                elapsed_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (in_req)
                            REQ_LOAD: begin
                                if (s_tlast) begin
                                    len_reg[in_list] <= {1'b0, in_step} + POS_W'(1);
                                end
                            end
                            REQ_START: begin
                                if ({1'b0, in_list} < cfg_reg) begin
                                    running_reg[in_list] <= 1'b1;
                                    pos_reg[in_list]     <= '0;
                                    rep_reg[in_list]     <= '0;
                                    elapsed_reg[in_list] <= '0;
                                end
                            end
                            REQ_STOP: running_reg[in_list] <= 1'b0;
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (running_reg[list_reg] && !cur_live) begin
                        running_reg[list_reg] <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (step_q.kind == KIND_FIRE || step_q.kind == KIND_SKIP) begin
                        pos_reg[list_reg]     <= pos_reg[list_reg] + POS_W'(1);
                        rep_reg[list_reg]     <= '0;
                        elapsed_reg[list_reg] <= '0;
                    end else begin
                        elapsed_reg[list_reg] <= alu_rsp.result;
                    end
                end
                S_CMP: begin
                    if (alu_rsp.ge) begin
                        if (step_q.kind == KIND_REPEAT) begin
                            elapsed_reg[list_reg] <= alu_rsp.result;
                            rep_reg[list_reg]     <= rep_reg[list_reg] + MS_W'(1);
                        end else begin
                            pos_reg[list_reg]     <= pos_reg[list_reg] + POS_W'(1);
                            rep_reg[list_reg]     <= '0;
                            elapsed_reg[list_reg] <= '0;
                        end
                    end
                end
                S_REP: begin
                    // enough firings done: move to the next step
                    if (alu_rsp.ge) begin
                        pos_reg[list_reg]     <= pos_reg[list_reg] + POS_W'(1);
                        rep_reg[list_reg]     <= '0;
                        elapsed_reg[list_reg] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= (state_reg == S_EMIT) || (state_reg == S_STAT);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (state_reg == S_EMIT) begin
                m_fired_reg <= 1'b1;
                m_list_reg  <= list_reg;
                m_event_reg <= ev_reg;
                m_any_reg   <= any_reg;
                m_last_reg  <= 1'b0;
            end else begin
                m_fired_reg <= 1'b0;
                m_list_reg  <= '0;
                m_event_reg <= '0;
                m_any_reg   <= any_run;
                m_last_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_fired_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0, m_any_reg, m_event_reg, m_list_reg};

    `TELS_ASSERT_NEXT(a_tick_walk, aclk, aresetn, tick_acc, state_reg == S_RD && list_reg == '0)
    `TELS_ASSERT_NEXT(a_stat_done, aclk, aresetn, stat_out, s_tready && m_tvalid && m_tlast)
    `TELS_ASSERT_NOW(a_last_zero, aclk, aresetn, m_tvalid && m_tlast, !m_tuser && ~|m_tdata[10:0])

endmodule

`default_nettype wire
